// ===== rtl/hashed_tag_membership_filter_assert.svh =====
// assertion macros shared by the filter modules
`ifndef HASHED_TAG_MEMBERSHIP_FILTER_ASSERT_SVH
`define HASHED_TAG_MEMBERSHIP_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HTMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htmf same-cycle check failed");

// next-cycle implication, disabled during reset
`define HTMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htmf next-cycle check failed");

`endif

// ===== rtl/htmf_pkg.sv =====
package htmf_pkg;

    // default geometry
    localparam int DEF_BUCKET_BITS = 16;
    localparam int DEF_TAG_BITS    = 8;
    localparam int DEF_KEY_BYTES   = 33;

    // hash constants
    localparam logic [63:0] HASH_SEED = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_byte;
    } key_beat_t;

    typedef struct packed {
        logic        maybe_present;
        logic [15:0] bucket_index;
        logic [7:0]  tag_value;
    } result_beat_t;

    // controller to datapath
    typedef struct packed {
        logic absorb;       // fold input byte with acc into mix operand, start a mix
        logic prod;         // partial products of mix operand
        logic sel_c2;       // second mix constant
        logic sum;          // combine products, xor-shift
        logic commit;       // mix result back into acc
        logic premix;       // xor-shift before the finishing mix
        logic key_restart;  // acc to seed, position to zero
        logic rd;           // read bitmap word
        logic upd;          // set bit on insert, load result
        logic clr_start;    // rewind clear counter
        logic clr_step;     // zero one bitmap word
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic key_clear;    // opcode of waiting beat is clear
        logic final_key;    // byte being mixed ends the key
        logic clr_last;     // clear counter at last word
        logic out_free;     // result register can take a beat
    } dp_sts_t;

    function automatic logic [63:0] xs33(input logic [63:0] x);
        return x ^ (x >> 33);
    endfunction

endpackage

// ===== rtl/htmf_ram.sv =====
module htmf_ram
    import htmf_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/htmf_ctrl.sv =====
`include "hashed_tag_membership_filter_assert.svh"

module htmf_ctrl
    import htmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_stall,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PROD1  = 4'd2;
    localparam logic [3:0] S_SUM1   = 4'd3;
    localparam logic [3:0] S_PROD2  = 4'd4;
    localparam logic [3:0] S_SUM2   = 4'd5;
    localparam logic [3:0] S_PREMIX = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_UPDATE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       pass2_reg;
    logic       pass2_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pass2_next = pass2_reg;
        key_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (key_valid)
                begin
                    if (sts.key_clear)
                    begin
                        cmd.clr_start   = 1'b1;
                        cmd.key_restart = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else
                    begin
                        cmd.absorb = 1'b1;
                        state_next = S_PROD1;
                    end
                end
            end
            S_PROD1:
            begin
                cmd.prod   = 1'b1;
                state_next = S_SUM1;
            end
            S_SUM1:
            begin
                cmd.sum    = 1'b1;
                state_next = S_PROD2;
            end
            S_PROD2:
            begin
                cmd.prod   = 1'b1;
                cmd.sel_c2 = 1'b1;
                state_next = S_SUM2;
            end
            S_SUM2:
            begin
                cmd.sum = 1'b1;
                if (pass2_reg)
                begin
                    pass2_next = 1'b0;
                    state_next = S_READ;
                end
                else if (sts.final_key)
                begin
                    state_next = S_PREMIX;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PREMIX:
            begin
                cmd.premix      = 1'b1;
                cmd.key_restart = 1'b1;
                pass2_next      = 1'b1;
                state_next      = S_PROD1;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                pass2_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    `HTMF_ASSERT_NXT(a_clear_enters_sweep, key_valid && !key_stall && sts.key_clear,
                     state_reg == S_CLEAR)
    `HTMF_ASSERT_IMP(a_upd_needs_room, cmd.upd, sts.out_free)
    `HTMF_ASSERT_IMP(a_one_datapath_op,
                     1'b1,
                     $onehot0({cmd.absorb, cmd.prod, cmd.sum, cmd.premix, cmd.rd, cmd.upd,
                               cmd.clr_step}))

endmodule

// ===== rtl/htmf_dp.sv =====
`include "hashed_tag_membership_filter_assert.svh"

module htmf_dp
    import htmf_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  key_beat_t    key_data,
    output result_beat_t result_data,
    output logic         result_valid,
    input  logic         result_stall,
    input  ctrl_cmd_t    cmd,
    output dp_sts_t      sts
);

    localparam int PAIR_BITS = BUCKET_BITS + TAG_BITS;
    localparam int WORD_AW   = (PAIR_BITS > 7) ? (PAIR_BITS - 6) : 1;
    localparam int PAIR_W    = WORD_AW + 6;
    localparam int MAP_WORDS = 1 << WORD_AW;
    localparam logic [5:0] LAST_POS = 6'(KEY_BYTES % 64);

    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;
    logic [5:0]         pos_reg;
    logic [5:0]         pos_next;
    logic               final_reg;
    logic               final_next;
    logic [1:0]         op_reg;
    logic [63:0]        v_reg;
    logic [63:0]        v_next;
    logic [63:0]        p_ll_reg;
    logic [31:0]        p_lh_reg;
    logic [31:0]        p_hl_reg;
    logic [WORD_AW-1:0] clr_cnt_reg;
    logic [WORD_AW-1:0] clr_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_beat_t       out_data_reg;

    logic [63:0]          lane_word;
    logic [63:0]          mix_const;
    logic [63:0]          prod_sum;
    logic [63:0]          mix_r;
    logic [BUCKET_BITS-1:0] bucket;
    logic [TAG_BITS-1:0]  tag;
    logic [PAIR_BITS-1:0] pair;
    logic [PAIR_W-1:0]    pair_ext;
    logic [WORD_AW-1:0]   word_addr;
    logic [63:0]          bit_mask;
    logic [63:0]          ram_rdata;
    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [63:0]          ram_wdata;
    logic                 was_set;

    // byte lane by position within the key
    assign lane_word = 64'(key_data.key_byte) << {pos_reg[2:0], 3'b000};
    assign mix_const = cmd.sel_c2 ? MIX_C2 : MIX_C1;
    // low 64 bits of the 64x64 product from three 32x32 partials
    assign prod_sum  = p_ll_reg + {p_lh_reg + p_hl_reg, 32'h0};
    assign mix_r     = xs33(prod_sum);

    // hash split
    assign bucket    = v_reg[BUCKET_BITS-1:0];
    assign tag       = v_reg[BUCKET_BITS +: TAG_BITS];
    assign pair      = {bucket, tag};
    assign pair_ext  = PAIR_W'(pair);
    assign word_addr = pair_ext[PAIR_W-1:6];
    assign bit_mask  = 64'(1) << pair_ext[5:0];
    assign was_set   = ram_rdata[pair_ext[5:0]];

    assign ram_we    = cmd.clr_step || (cmd.upd && (op_reg == OP_INSERT));
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : word_addr;
    assign ram_wdata = cmd.clr_step ? 64'h0 : (ram_rdata | bit_mask);

    htmf_ram #(
        .WIDTH (64),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (word_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        final_next   = final_reg;
        v_next       = v_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.absorb)
        begin
            v_next     = xs33(acc_reg ^ lane_word);
            pos_next   = pos_reg + 6'd1;
            final_next = ((pos_reg + 6'd1) == LAST_POS);
        end
        if (cmd.sum)
        begin
            v_next = mix_r;
        end
        if (cmd.premix)
        begin
            v_next = xs33(v_reg);
        end
        if (cmd.commit)
        begin
            acc_next = mix_r;
        end
        if (cmd.key_restart)
        begin
            acc_next = HASH_SEED;
            pos_next = 6'd0;
        end
        if (cmd.clr_start)
        begin
            clr_cnt_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + WORD_AW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.upd)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= HASH_SEED;
            pos_reg       <= 6'd0;
            final_reg     <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            final_reg     <= final_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (cmd.absorb)
        begin
            op_reg <= key_data.opcode;
        end
        if (cmd.prod)
        begin
            p_ll_reg <= 64'(v_reg[31:0]) * 64'(mix_const[31:0]);
            p_lh_reg <= v_reg[31:0] * mix_const[63:32];
            p_hl_reg <= v_reg[63:32] * mix_const[31:0];
        end
        if (cmd.upd)
        begin
            out_data_reg.maybe_present <= was_set;
            out_data_reg.bucket_index  <= 16'(bucket);
            out_data_reg.tag_value     <= 8'(tag);
        end
    end

    assign result_valid  = out_valid_reg;
    assign result_data   = out_data_reg;

    assign sts.key_clear = (key_data.opcode == OP_CLEAR);
    assign sts.final_key = final_reg;
    assign sts.clr_last  = &clr_cnt_reg;
    assign sts.out_free  = !out_valid_reg || !result_stall;

    `HTMF_ASSERT_IMP(a_sweep_writes_zero, cmd.clr_step, ram_we && (ram_wdata == 64'h0))
    `HTMF_ASSERT_NXT(a_upd_shows_result, cmd.upd, out_valid_reg)
    `HTMF_ASSERT_NXT(a_restart_to_seed, cmd.key_restart,
                     (acc_reg == HASH_SEED) && (pos_reg == 6'd0))

endmodule

// ===== rtl/hashed_tag_membership_filter.sv =====
// channel   direction  beat type       handshake
// key       in         key_beat_t      key_valid / key_stall
// result    out        result_beat_t   result_valid / result_stall
//
// a key byte that does not end its key is accepted, then runs two mix rounds of
//   product and sum, each 64x64 product built from three registered 32x32 partials
// the last byte of a key runs its own mix, a second finishing mix, then a read of one
//   64-bit bitmap word of the single-port-write ram, written back on insert
// a clear beat, and reset, run a sweep over 2^(BUCKET_BITS+TAG_BITS-6) words (262144 at
//   default geometry) zeroing one word per cycle; no key beat is taken meanwhile
// the result sits in an output register; a stalled result only holds the block when the
//   next key completes before the previous result is taken
module hashed_tag_membership_filter
    import htmf_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         key_valid,
    output logic         key_stall,
    input  key_beat_t    key_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_beat_t result_data
);

    // command and status between sequencer and datapath
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // sequencer: clear sweep, mix rounds, bitmap access
    htmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: accumulator, shared multiplier partials, bitmap ram, result register
    htmf_dp #(
        .BUCKET_BITS (BUCKET_BITS),
        .TAG_BITS    (TAG_BITS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_data     (key_data),
        .result_data  (result_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
